/* rtl/bbc_pkg.sv */
// Types, codes and bracket decode shared by the bracket balance checker.
`default_nettype none
package bbc_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned LINE_W = 16;
  localparam int unsigned KIND_W = 2;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [LINE_W-1:0] line_t;
  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [2:0] {
    ST_RUN       = 3'd0,
    ST_UNMATCHED = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_UNCLOSED  = 3'd3,
    ST_BALANCED  = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  localparam kind_t KIND_NONE   = 2'd0;
  localparam kind_t KIND_BRACE  = 2'd1;
  localparam kind_t KIND_PAREN  = 2'd2;
  localparam kind_t KIND_SQUARE = 2'd3;

  localparam char_t CHAR_NEWLINE     = 8'd10;
  localparam char_t CHAR_OPEN_BRACE  = 8'h7B;
  localparam char_t CHAR_OPEN_PAREN  = 8'h28;
  localparam char_t CHAR_OPEN_SQUARE = 8'h5B;
  localparam char_t CHAR_CLOSE_BRACE  = 8'h7D;
  localparam char_t CHAR_CLOSE_PAREN  = 8'h29;
  localparam char_t CHAR_CLOSE_SQUARE = 8'h5D;

  localparam line_t LINE_FIRST = 16'd1;
  localparam line_t LINE_MAX   = 16'hFFFF;

  function automatic kind_t opener_kind(input char_t c);
    kind_t k;
    case (c)
      CHAR_OPEN_BRACE:  k = KIND_BRACE;
      CHAR_OPEN_PAREN:  k = KIND_PAREN;
      CHAR_OPEN_SQUARE: k = KIND_SQUARE;
      default:          k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t closer_kind(input char_t c);
    kind_t k;
    case (c)
      CHAR_CLOSE_BRACE:  k = KIND_BRACE;
      CHAR_CLOSE_PAREN:  k = KIND_PAREN;
      CHAR_CLOSE_SQUARE: k = KIND_SQUARE;
      default:           k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

/* rtl/bbc_stream_if.sv */
// Request and result channel interfaces of the bracket balance checker.
`default_nettype none
interface bbc_in_if import bbc_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t char_code;
  logic  end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface bbc_out_if import bbc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] status;
  line_t      line_number;
  kind_t      closer_kind;
  kind_t      expected_kind;
  kind_t      found_opener;

  modport source (output valid, output status, output line_number, output closer_kind,
                  output expected_kind, output found_opener, input ready);
  modport sink (input valid, input status, input line_number, input closer_kind,
                input expected_kind, input found_opener, output ready);
endinterface
`default_nettype wire

/* rtl/bracket_balance_checker_top.sv */
// Bracket balance checker: request register, stack logic and result register.
// Accepted requests wait in the request register; results in the result register.
// Throughput: one request per cycle while the result channel is ready; the top of
// stack and the entry below it are registers, and the stack memory sees at most one
// write and one read a cycle. Reset clears the stack count, line count, error state
// and both valid flags; stack memory contents are not cleared.
`default_nettype none
module bracket_balance_checker_top import bbc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire  clk,
  input  wire  rst_n,
  bbc_in_if.sink    in_req,
  bbc_out_if.source out_res
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic          req_valid_r;
  char_t         req_char_r;
  logic          req_last_r;
  logic          advance;

  logic [CW-1:0] cnt_r, cnt_nxt;
  kind_t         tos_r, tos_nxt;
  kind_t         under_r;
  line_t         line_r, line_nxt;
  status_t       err_r, err_nxt;
  line_t         e_line_r, e_line_nxt;
  kind_t         e_cl_r, e_cl_nxt;
  kind_t         e_ex_r, e_ex_nxt;
  kind_t         e_fo_r, e_fo_nxt;

  logic          we;
  logic [CW-1:0] wa_full, ra_full;
  kind_t         stack_mem [STACK_DEPTH];

  logic          res_valid_r;
  status_t       res_st_r, res_st_nxt;
  line_t         res_line_r, res_line_nxt;
  kind_t         res_cl_r, res_cl_nxt;
  kind_t         res_ex_r, res_ex_nxt;
  kind_t         res_fo_r, res_fo_nxt;

  kind_t         ok, ck;

  assign advance      = req_valid_r && (!res_valid_r || out_res.ready);
  assign in_req.ready = !req_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      req_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_char_r <= in_req.char_code;
      req_last_r <= in_req.end_of_text;
    end
  end

  assign ok      = opener_kind(req_char_r);
  assign ck      = closer_kind(req_char_r);
  assign wa_full = cnt_r - CW'(1);
  assign ra_full = cnt_nxt - CW'(2);

  always_comb begin
    cnt_nxt      = cnt_r;
    tos_nxt      = tos_r;
    line_nxt     = line_r;
    err_nxt      = err_r;
    e_line_nxt   = e_line_r;
    e_cl_nxt     = e_cl_r;
    e_ex_nxt     = e_ex_r;
    e_fo_nxt     = e_fo_r;
    we           = 1'b0;
    res_st_nxt   = ST_RUN;
    res_line_nxt = line_r;
    res_cl_nxt   = KIND_NONE;
    res_ex_nxt   = KIND_NONE;
    res_fo_nxt   = KIND_NONE;
    if (advance) begin
      if (err_r == ST_RUN) begin
        if (ok != KIND_NONE) begin
          if (cnt_r == CW'(STACK_DEPTH)) begin
            err_nxt    = ST_OVERFLOW;
            e_line_nxt = line_r;
            e_cl_nxt   = KIND_NONE;
            e_ex_nxt   = KIND_NONE;
            e_fo_nxt   = ok;
          end else begin
            we      = (cnt_r != '0);
            tos_nxt = ok;
            cnt_nxt = cnt_r + CW'(1);
          end
        end else if (ck != KIND_NONE) begin
          if (cnt_r == '0) begin
            err_nxt    = ST_UNMATCHED;
            e_line_nxt = line_r;
            e_cl_nxt   = ck;
            e_ex_nxt   = ck;
            e_fo_nxt   = KIND_NONE;
          end else begin
            cnt_nxt = cnt_r - CW'(1);
            tos_nxt = under_r;
            if (tos_r != ck) begin
              err_nxt    = ST_MISMATCH;
              e_line_nxt = line_r;
              e_cl_nxt   = ck;
              e_ex_nxt   = ck;
              e_fo_nxt   = tos_r;
            end
          end
        end else if (req_char_r == CHAR_NEWLINE && line_r != LINE_MAX) begin
          line_nxt = line_r + LINE_FIRST;
        end
      end
      if (err_nxt != ST_RUN) begin
        res_st_nxt   = err_nxt;
        res_line_nxt = e_line_nxt;
        res_cl_nxt   = e_cl_nxt;
        res_ex_nxt   = e_ex_nxt;
        res_fo_nxt   = e_fo_nxt;
      end else if (req_last_r) begin
        if (cnt_nxt != '0) begin
          res_st_nxt = ST_UNCLOSED;
          res_ex_nxt = tos_nxt;
          res_fo_nxt = tos_nxt;
        end else begin
          res_st_nxt = ST_BALANCED;
        end
      end
      if (req_last_r) begin
        cnt_nxt  = '0;
        line_nxt = LINE_FIRST;
        err_nxt  = ST_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      line_r <= LINE_FIRST;
      err_r  <= ST_RUN;
    end else begin
      cnt_r  <= cnt_nxt;
      line_r <= line_nxt;
      err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r    <= tos_nxt;
    e_line_r <= e_line_nxt;
    e_cl_r   <= e_cl_nxt;
    e_ex_r   <= e_ex_nxt;
    e_fo_r   <= e_fo_nxt;
  end

  // hold entries below the top; forward the write when it hits the read address
  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem[wa_full[AW-1:0]] <= tos_r;
    end
    if (we && (wa_full[AW-1:0] == ra_full[AW-1:0])) begin
      under_r <= tos_r;
    end else begin
      under_r <= stack_mem[ra_full[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_st_r   <= res_st_nxt;
      res_line_r <= res_line_nxt;
      res_cl_r   <= res_cl_nxt;
      res_ex_r   <= res_ex_nxt;
      res_fo_r   <= res_fo_nxt;
    end
  end

  assign out_res.valid         = res_valid_r;
  assign out_res.status        = res_st_r;
  assign out_res.line_number   = res_line_r;
  assign out_res.closer_kind   = res_cl_r;
  assign out_res.expected_kind = res_ex_r;
  assign out_res.found_opener  = res_fo_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && req_last_r |=> cnt_r == '0 && line_r == LINE_FIRST && err_r == ST_RUN)
    else $error("state not cleared after last request");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !req_last_r && err_r != ST_RUN |=> err_r == $past(err_r))
    else $error("latched error changed within a text");

  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance && err_r != ST_RUN |=> res_st_r == $past(err_r) && res_line_r == $past(e_line_r))
    else $error("latched error not reported");

endmodule
`default_nettype wire

/* tb/bbc_result_checker.sv */
`timescale 1ns / 100ps
// Result checker: predicts the status of every accepted byte and compares it with the block's output.
module bbc_result_checker import bbc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  bbc_in_if           in_mon,
  bbc_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    status_t status;
    line_t   line_no;
    kind_t   closer;
    kind_t   expected;
    kind_t   found;
  } bbc_result_t;

  localparam bbc_result_t NO_ERROR = '{status: ST_RUN, line_no: '0, closer: KIND_NONE,
                                       expected: KIND_NONE, found: KIND_NONE};

  kind_t       stack_mem [STACK_DEPTH];
  int unsigned depth;
  line_t       cur_line;
  bbc_result_t held_err;
  bbc_result_t status_due_q [$];

  function automatic kind_t bracket_open_kind(input char_t c);
    case (c)
      CHAR_OPEN_BRACE:  return KIND_BRACE;
      CHAR_OPEN_PAREN:  return KIND_PAREN;
      CHAR_OPEN_SQUARE: return KIND_SQUARE;
      default:          return KIND_NONE;
    endcase
  endfunction

  function automatic kind_t bracket_close_kind(input char_t c);
    case (c)
      CHAR_CLOSE_BRACE:  return KIND_BRACE;
      CHAR_CLOSE_PAREN:  return KIND_PAREN;
      CHAR_CLOSE_SQUARE: return KIND_SQUARE;
      default:           return KIND_NONE;
    endcase
  endfunction

  task automatic predict_status(input char_t c, input logic eot, output bbc_result_t r);
    kind_t ok;
    kind_t ck;
    kind_t top_k;
    line_t line_no;
    line_no = cur_line;
    r = '{status: ST_RUN, line_no: line_no, closer: KIND_NONE, expected: KIND_NONE,
          found: KIND_NONE};
    if (held_err.status == ST_RUN) begin
      ok = bracket_open_kind(c);
      ck = bracket_close_kind(c);
      if (ok != KIND_NONE) begin
        if (depth >= STACK_DEPTH) begin
          held_err = '{status: ST_OVERFLOW, line_no: line_no, closer: KIND_NONE,
                       expected: KIND_NONE, found: ok};
        end else begin
          stack_mem[depth] = ok;
          depth++;
        end
      end else if (ck != KIND_NONE) begin
        if (depth == 0) begin
          held_err = '{status: ST_UNMATCHED, line_no: line_no, closer: ck, expected: ck,
                       found: KIND_NONE};
        end else begin
          depth--;
          top_k = stack_mem[depth];
          if (top_k != ck) begin
            held_err = '{status: ST_MISMATCH, line_no: line_no, closer: ck, expected: ck,
                         found: top_k};
          end
        end
      end else if (c == CHAR_NEWLINE && cur_line != LINE_MAX) begin
        cur_line++;
      end
      if (held_err.status == ST_RUN && eot) begin
        if (depth != 0) begin
          top_k = stack_mem[depth-1];
          r = '{status: ST_UNCLOSED, line_no: line_no, closer: KIND_NONE, expected: top_k,
                found: top_k};
        end else begin
          r.status = ST_BALANCED;
        end
      end
    end
    if (held_err.status != ST_RUN) r = held_err;
    if (eot) begin
      depth    = 0;
      cur_line = LINE_FIRST;
      held_err = NO_ERROR;
    end
  endtask

  function automatic int unsigned field_check(input string name, input logic [15:0] exp_v,
                                              input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : monitor
    bbc_result_t exp_r;
    if (!rst_n) begin
      depth      = 0;
      cur_line   = LINE_FIRST;
      held_err   = NO_ERROR;
      fail_count = 0;
      status_due_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        predict_status(in_mon.char_code, in_mon.end_of_text, exp_r);
        status_due_q.push_back(exp_r);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (status_due_q.size() == 0) begin
          $error("result with no request waiting: status %0d", out_mon.status);
          fail_count++;
        end else begin
          exp_r = status_due_q.pop_front();
          fail_count += field_check("status", 16'(exp_r.status), 16'(out_mon.status));
          fail_count += field_check("line_number", exp_r.line_no, out_mon.line_number);
          fail_count += field_check("closer_kind", 16'(exp_r.closer),
                                    16'(out_mon.closer_kind));
          fail_count += field_check("expected_kind", 16'(exp_r.expected),
                                    16'(out_mon.expected_kind));
          fail_count += field_check("found_opener", 16'(exp_r.found),
                                    16'(out_mon.found_opener));
        end
      end
    end
    pending = status_due_q.size();
  end

endmodule

/* tb/bracket_balance_checker_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top: clock, reset, byte stream stimulus, watchdog and verdict for the bracket checker.
module bracket_balance_checker_top_tb;
  import bbc_pkg::*;

  localparam int unsigned STACK_DEPTH  = 64;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned STRETCH_NEWLINES = 200;
  localparam int unsigned SETTLE_CYCLES = 10;

  logic        clk;
  logic        rst_n;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned sent_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned fail_count;
  int unsigned pending;
  char_t       text_q [$];

  bbc_in_if  in_ch ();
  bbc_out_if out_ch ();

  bracket_balance_checker_top #(.STACK_DEPTH(STACK_DEPTH)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_res (out_ch)
  );

  bbc_result_checker #(.STACK_DEPTH(STACK_DEPTH)) result_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic char_t open_char(input kind_t k);
    case (k)
      KIND_BRACE: return CHAR_OPEN_BRACE;
      KIND_PAREN: return CHAR_OPEN_PAREN;
      default:    return CHAR_OPEN_SQUARE;
    endcase
  endfunction

  function automatic char_t close_char(input kind_t k);
    case (k)
      KIND_BRACE: return CHAR_CLOSE_BRACE;
      KIND_PAREN: return CHAR_CLOSE_PAREN;
      default:    return CHAR_CLOSE_SQUARE;
    endcase
  endfunction

  function automatic kind_t any_kind();
    return kind_t'($urandom_range(3, 1));
  endfunction

  function automatic bit is_bracket(input char_t c);
    return c == CHAR_OPEN_BRACE || c == CHAR_OPEN_PAREN || c == CHAR_OPEN_SQUARE ||
           c == CHAR_CLOSE_BRACE || c == CHAR_CLOSE_PAREN || c == CHAR_CLOSE_SQUARE;
  endfunction

  function automatic char_t filler_char();
    char_t c;
    if ($urandom_range(5) == 0) return CHAR_NEWLINE;
    c = char_t'($urandom_range(255));
    while (is_bracket(c)) c = char_t'($urandom_range(255));
    return c;
  endfunction

  task automatic send_byte(input char_t c, input logic eot);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_code   <= c;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic build_nested(input int unsigned len, input int unsigned max_depth,
                              input bit close_all, input bit corrupt);
    kind_t       open_q [$];
    int unsigned i;
    int unsigned pick;
    kind_t       k;
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(2);
      if (pick == 0 && open_q.size() < max_depth) begin
        k = any_kind();
        open_q.push_back(k);
        text_q.push_back(open_char(k));
      end else if (pick == 1 && open_q.size() > 0) begin
        k = open_q.pop_back();
        text_q.push_back(close_char(k));
      end else begin
        text_q.push_back(filler_char());
      end
    end
    if (close_all) begin
      while (open_q.size() > 0) begin
        k = open_q.pop_back();
        text_q.push_back(close_char(k));
      end
    end
    if (text_q.size() == 0) text_q.push_back(filler_char());
    if (corrupt) text_q[$urandom_range(text_q.size() - 1)] = close_char(any_kind());
  endtask

  task automatic build_deep();
    int unsigned n;
    int unsigned i;
    n = $urandom_range(STACK_DEPTH + 2, STACK_DEPTH - 2);
    for (i = 0; i < n; i++) text_q.push_back(open_char(any_kind()));
    n = $urandom_range(4);
    for (i = 0; i < n; i++) text_q.push_back(close_char(any_kind()));
    text_q.push_back(filler_char());
  endtask

  task automatic build_noise();
    int unsigned n;
    int unsigned i;
    n = $urandom_range(30, 1);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0:       text_q.push_back(open_char(any_kind()));
        1:       text_q.push_back(close_char(any_kind()));
        2:       text_q.push_back(filler_char());
        default: text_q.push_back(char_t'($urandom_range(255)));
      endcase
    end
  endtask

  initial begin : stimulus
    int unsigned rand_start;
    int unsigned mode;
    int unsigned i;
    in_ch.valid       = 1'b0;
    in_ch.char_code   = '0;
    in_ch.end_of_text = 1'b0;
    rst_n             = 1'b0;
    in_idle_pct       = 16;
    out_idle_pct      = 16;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    text_q = '{CHAR_OPEN_BRACE, CHAR_OPEN_PAREN, CHAR_OPEN_SQUARE, CHAR_NEWLINE,
               CHAR_CLOSE_SQUARE, CHAR_CLOSE_PAREN, CHAR_CLOSE_BRACE};
    send_text();
    text_q = '{8'h00, 8'hFF};
    send_text();
    text_q = '{CHAR_CLOSE_PAREN};
    send_text();
    text_q = '{CHAR_OPEN_PAREN, CHAR_CLOSE_SQUARE, CHAR_CLOSE_BRACE, CHAR_NEWLINE, 8'h78};
    send_text();
    text_q = '{CHAR_OPEN_SQUARE, CHAR_NEWLINE, CHAR_OPEN_BRACE};
    send_text();
    text_q = '{CHAR_CLOSE_SQUARE, CHAR_OPEN_PAREN};
    send_text();
    text_q = '{CHAR_CLOSE_BRACE};
    send_text();

    // hold the sender until every result is back
    drain();

    // long stretch without idling
    in_idle_pct  = 0;
    out_idle_pct = 0;
    for (i = 0; i < STRETCH_NEWLINES; i++) text_q.push_back(CHAR_NEWLINE);
    text_q.push_back(CHAR_OPEN_SQUARE);
    text_q.push_back(CHAR_CLOSE_BRACE);
    send_text();
    text_q = '{CHAR_OPEN_BRACE, CHAR_NEWLINE};
    send_text();
    in_idle_pct  = 16;
    out_idle_pct = 16;

    rand_start = sent_count;
    while (sent_count - rand_start < RANDOM_ITEMS) begin
      mode = $urandom_range(99);
      if (mode < 60)      build_nested($urandom_range(40, 1), $urandom_range(8, 1), 1'b1, 1'b0);
      else if (mode < 72) build_nested($urandom_range(30, 1), $urandom_range(8, 1), 1'b0, 1'b0);
      else if (mode < 84) build_nested($urandom_range(30, 2), $urandom_range(8, 1), 1'b1, 1'b1);
      else if (mode < 95) build_noise();
      else                build_deep();
      send_text();
      if ($urandom_range(49) == 0) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bbc_pkg.sv
rtl/bbc_stream_if.sv
rtl/bracket_balance_checker_top.sv
tb/bbc_result_checker.sv
tb/bracket_balance_checker_top_tb.sv
